// ----- rtl/lltr_pkg.sv -----
// lltr_pkg: shared types and constants for the lfu/lru replacement block
// holds the operation codes, the per-cell update command and port widths
// no dependencies
`default_nettype none

package lltr_pkg;

	// default sizes for the top level parameters
	localparam int WAYS_DEF       = 8;
	localparam int COUNT_BITS_DEF = 16;
	localparam int TIME_BITS_DEF  = 32;

	// fixed field widths of the streams
	localparam int WAY_W     = 3;
	localparam int NOW_W     = 32;
	localparam int MASK_W    = 8;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 8;

	// operation codes
	typedef enum logic [1:0] {
		FN_INVAL  = 2'd0,
		FN_TOUCH  = 2'd1,
		FN_INSERT = 2'd2,
		FN_FIND   = 2'd3
	} func_t;

	// update command handed to one cell
	typedef struct packed {
		logic             sel;
		func_t            func;
		logic [NOW_W-1:0] now;
	} upd_t;

endpackage

`default_nettype wire

// ----- rtl/lfu_lru_tiebreak_replacement.sv -----
// lfu_lru_tiebreak_replacement: lfu replacement state for one cache set with lru tie-break
// top level: stream ports, control and a chain of lltr_cell, one per way
// depends on lltr_pkg and lltr_cell
//
// usage
//   s_* carries one operation per item: invalidate, touch, insert or find victim.
//   m_* returns exactly one result item per accepted item, in order.
//   invalidate, touch and insert update the addressed way at the accepting edge
//   and give their result (victim 0, no_candidate 0) in the cycle after; one such
//   item can be taken every cycle while m_tready is high.
//   find victim sends a search token down the chain of way cells, one cell per
//   cycle, and the result register is loaded when the token leaves the last cell;
//   s_tready stays low while the search runs.
//   results wait in an output register; while it is full and m_tready is low
//   no new item is taken.
//   reset clears all counts and times to zero and empties the output register.
`default_nettype none

module lfu_lru_tiebreak_replacement #(
	parameter int WAYS       = lltr_pkg::WAYS_DEF,
	parameter int COUNT_BITS = lltr_pkg::COUNT_BITS_DEF,
	parameter int TIME_BITS  = lltr_pkg::TIME_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// func[1:0], way[4:2], now[36:5], candidate_mask[44:37], zero fill
	input  wire  [lltr_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// victim_way[2:0], no_candidate[3], zero fill
	output logic [lltr_pkg::M_TDATA_W-1:0]     m_tdata
);

	localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	lltr_pkg::func_t                 in_func;
	logic [lltr_pkg::WAY_W-1:0]      in_way;
	logic [lltr_pkg::NOW_W-1:0]      in_now;
	logic [lltr_pkg::MASK_W-1:0]     in_mask;
	logic                            accept;

	logic                            busy_q;
	logic                            launch_q;
	logic [lltr_pkg::MASK_W-1:0]     mask_q;
	logic                            out_valid_q;
	logic [lltr_pkg::WAY_W-1:0]      victim_q;
	logic                            empty_q;

	logic [WAYS-1:0]                 cand;
	logic                            tok_l   [WAYS+1];
	logic                            found_l [WAYS+1];
	logic [COUNT_BITS-1:0]           cnt_l   [WAYS+1];
	logic [TIME_BITS-1:0]            time_l  [WAYS+1];
	logic [IDX_W-1:0]                idx_l   [WAYS+1];
	logic [WAYS-1:0]                 tok_w;

	// unpack the input item
	assign in_func = lltr_pkg::func_t'(s_tdata[1:0]);
	assign in_way  = s_tdata[4:2];
	assign in_now  = s_tdata[36:5];
	assign in_mask = s_tdata[44:37];

	assign s_tready = !busy_q && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// control: search launch, busy flag and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q <= accept && (in_func == lltr_pkg::FN_FIND);
			if (accept) begin
				if (in_func == lltr_pkg::FN_FIND) begin
					busy_q      <= 1'b1;
					out_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (tok_l[WAYS]) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload and query mask
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q   <= in_mask;
			victim_q <= '0;
			empty_q  <= 1'b0;
		end else if (tok_l[WAYS]) begin
			victim_q <= found_l[WAYS] ? lltr_pkg::WAY_W'(idx_l[WAYS]) : '0;
			empty_q  <= !found_l[WAYS];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, empty_q, victim_q};

	// head of the search chain
	assign tok_l[0]   = launch_q;
	assign found_l[0] = 1'b0;
	assign cnt_l[0]   = '0;
	assign time_l[0]  = '0;
	assign idx_l[0]   = '0;

	// one cell per way
	for (genvar i = 0; i < WAYS; i++) begin : g_cell
		lltr_pkg::upd_t upd;

		if (i < lltr_pkg::MASK_W) begin : g_mask
			assign cand[i] = mask_q[i];
		end else begin : g_nomask
			assign cand[i] = 1'b0;
		end

		assign upd.sel  = accept && (in_func != lltr_pkg::FN_FIND) &&
			(32'(in_way) == i);
		assign upd.func = in_func;
		assign upd.now  = in_now;

		lltr_cell #(
			.COUNT_BITS (COUNT_BITS),
			.TIME_BITS  (TIME_BITS),
			.IDX_W      (IDX_W),
			.IDX        (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (upd),
			.cand     (cand[i] && tok_l[i]),
			.tok_in   (tok_l[i]),
			.found_in (found_l[i]),
			.cnt_in   (cnt_l[i]),
			.time_in  (time_l[i]),
			.idx_in   (idx_l[i]),
			.tok_s1   (tok_l[i+1]),
			.found_s1 (found_l[i+1]),
			.cnt_s1   (cnt_l[i+1]),
			.time_s1  (time_l[i+1]),
			.idx_s1   (idx_l[i+1])
		);

		assign tok_w[i] = tok_l[i+1];
	end

`ifndef SYNTHESIS
	// at most one search token in flight
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({tok_w, launch_q}) <= 1)
		else $error("more than one search token in the chain");

	// no token outside a search
	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tok_w == '0) && !launch_q)
		else $error("search token while not busy");

	// the result register is free while a search runs
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !out_valid_q)
		else $error("result pending during a search");

	// a search ends in a result and clears the busy flag
	a_search_done: assert property (@(posedge clk) disable iff (!arst_n)
		tok_l[WAYS] |=> out_valid_q && !busy_q)
		else $error("search finished without a result");
`endif

endmodule

`default_nettype wire

// ----- rtl/lltr_cell.sv -----
// lltr_cell: one way of the set, holding its reference count and touch time
// also one stage of the victim search chain, passing the best way so far on
// depends on lltr_pkg
`default_nettype none

module lltr_cell #(
	parameter int COUNT_BITS = lltr_pkg::COUNT_BITS_DEF,
	parameter int TIME_BITS  = lltr_pkg::TIME_BITS_DEF,
	parameter int IDX_W      = 3,
	parameter int IDX        = 0
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire lltr_pkg::upd_t   upd,
	input  wire                   cand,
	input  wire                   tok_in,
	input  wire                   found_in,
	input  wire  [COUNT_BITS-1:0] cnt_in,
	input  wire  [TIME_BITS-1:0]  time_in,
	input  wire  [IDX_W-1:0]      idx_in,
	output logic                  tok_s1,
	output logic                  found_s1,
	output logic [COUNT_BITS-1:0] cnt_s1,
	output logic [TIME_BITS-1:0]  time_s1,
	output logic [IDX_W-1:0]      idx_s1
);

	logic [COUNT_BITS-1:0] cnt_q;
	logic [TIME_BITS-1:0]  time_q;
	logic                  take;

	// replacement state of this way
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			time_q <= '0;
		end else if (upd.sel) begin
			unique case (upd.func)
				lltr_pkg::FN_INVAL: begin
					cnt_q  <= '0;
					time_q <= '0;
				end
				lltr_pkg::FN_TOUCH: begin
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + COUNT_BITS'(1);
					end
					time_q <= TIME_BITS'(upd.now);
				end
				lltr_pkg::FN_INSERT: begin
					cnt_q  <= COUNT_BITS'(1);
					time_q <= TIME_BITS'(upd.now);
				end
				lltr_pkg::FN_FIND: begin
				end
				default: begin
				end
			endcase
		end
	end

	// this way beats the best so far: lower count, then older time
	assign take = cand && (!found_in || (cnt_q < cnt_in) ||
		((cnt_q == cnt_in) && (time_q < time_in)));

	// search token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= 1'b0;
		end else begin
			tok_s1 <= tok_in;
		end
	end

	// best way so far, handed to the next cell
	always_ff @(posedge clk) begin
		found_s1 <= found_in | cand;
		if (take) begin
			cnt_s1  <= cnt_q;
			time_s1 <= time_q;
			idx_s1  <= IDX_W'(IDX);
		end else begin
			cnt_s1  <= cnt_in;
			time_s1 <= time_in;
			idx_s1  <= idx_in;
		end
	end

endmodule

`default_nettype wire
